// ----- hdl/uhpft_pkg.sv -----
// Shared types and constants for the hub port feature tracker.
`timescale 1ns / 1ps

package uhpft_pkg;

  // Number of hub ports, port 0 is the hub itself (2 to 8)
  localparam int unsigned PORTS = 3;
  localparam int unsigned PortW = (PORTS > 1) ? $clog2(PORTS) : 1;

  // Status word bit positions
  localparam int unsigned FeatLimit     = 32;
  localparam int unsigned BitConnection = 0;
  localparam int unsigned BitEnable     = 1;
  localparam int unsigned BitReset      = 4;
  localparam int unsigned BitCConnect   = 16;
  localparam int unsigned BitCReset     = 20;

  localparam logic [31:0] ConnectBits =
    (32'd1 << BitConnection) | (32'd1 << BitCConnect);

  // Request kinds
  typedef enum logic [2:0] {
    MODE_SET    = 3'd0,
    MODE_CLEAR  = 3'd1,
    MODE_GET    = 3'd2,
    MODE_TAKEN  = 3'd3,
    MODE_REINIT = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  feature_sel;
    logic [15:0] port_index;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] status_word;
    logic        report_valid;
    logic [7:0]  report_mask;
  } res_t;

endpackage

// ----- hdl/uhpft_core.sv -----
// Port status register file, change mask and request decode.
`timescale 1ns / 1ps

module uhpft_core
  import uhpft_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,     // commit the request on this edge
  input  req_t req_i,
  output res_t res_o
);

  logic [31:0] status_q [PORTS];
  logic [31:0] status_d [PORTS];
  logic [7:0]  mask_q, mask_d;

  logic             feat_ok, sc_port_ok, gs_port_ok, sc_ok;
  logic [PortW-1:0] idx;
  logic [31:0]      word, bit_sel, new_word;
  logic             hit, flip, mark;

  // Range checks and read of the addressed port
  always_comb begin
    feat_ok    = (32'(req_i.feature_sel) < FeatLimit);
    sc_port_ok = (32'(req_i.port_index[7:0]) < PORTS);
    gs_port_ok = (32'(req_i.port_index) < PORTS);
    sc_ok      = feat_ok && sc_port_ok;
    idx        = req_i.port_index[PortW-1:0];
    word       = status_q[idx];
    bit_sel    = 32'd1 << req_i.feature_sel[4:0];
    hit        = |(word & bit_sel);
  end

  // Next status word and change mask
  always_comb begin
    flip     = 1'b0;
    new_word = word;
    mask_d   = mask_q;
    for (int p = 0; p < PORTS; p++) begin
      status_d[p] = status_q[p];
    end
    res_o = '0;

    case (req_i.mode)
      MODE_SET: begin
        if (sc_ok) begin
          res_o.accepted = 1'b1;
          flip           = !hit;
          new_word       = word | bit_sel;
          // port reset completes at once: reset change and enable instead
          if (req_i.feature_sel == 8'(BitReset)) begin
            new_word = (new_word & ~(32'd1 << BitReset))
                     | (32'd1 << BitCReset) | (32'd1 << BitEnable);
          end
        end
      end
      MODE_CLEAR: begin
        if (sc_ok) begin
          res_o.accepted = 1'b1;
          flip           = hit;
          new_word       = word & ~bit_sel;
        end
      end
      MODE_GET: begin
        if (gs_port_ok) begin
          res_o.accepted    = 1'b1;
          res_o.status_word = word;
        end
      end
      MODE_TAKEN: begin
        res_o.accepted = 1'b1;
        mask_d         = '0;
      end
      MODE_REINIT: begin
        res_o.accepted = 1'b1;
        for (int p = 1; p < PORTS; p++) begin
          status_d[p] = ConnectBits;
        end
      end
      default: begin
        res_o.accepted = 1'b0;
      end
    endcase

    // Only bits below the change half mark the port
    mark = flip && !req_i.feature_sel[4];
    if (flip) begin
      status_d[idx] = new_word;
    end
    if (mark) begin
      mask_d = mask_q | (8'd1 << idx);
    end

    if ((req_i.mode == MODE_SET || req_i.mode == MODE_CLEAR) && mask_d != mask_q) begin
      res_o.report_valid = 1'b1;
      res_o.report_mask  = mask_d;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PORTS; p++) begin
        status_q[p] <= (p == 0) ? 32'd0 : ConnectBits;
      end
      mask_q <= '0;
    end else if (en_i) begin
      for (int p = 0; p < PORTS; p++) begin
        status_q[p] <= status_d[p];
      end
      mask_q <= mask_d;
    end
  end

  // Checks
  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.mode == MODE_TAKEN |=> mask_q == '0)
    else $error("change mask not cleared after report taken");

  a_stall_keeps_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !res_o.accepted |=> $stable(mask_q))
    else $error("stalled request changed the change mask");

  a_report_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.report_valid |-> res_o.accepted && res_o.report_mask != '0)
    else $error("report on a stalled request or with an empty mask");

  a_hub_word_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.mode == MODE_REINIT |=> $stable(mask_q) && status_q[0] == $past(status_q[0]))
    else $error("reinit touched the change mask or the hub word");

endmodule

// ----- hdl/usb_hub_port_feature_tracker.sv -----
// Top level: stream handshake around the hub port feature tracker.
// Path: a request accepted into the input register is decoded by the core
// and its result is captured in the result register, which drives tvalid.
// Throughput: one request per cycle while m_axis_tready does not stall it.
// Reset: asynchronous, active low; both stages empty, hub word zero, other
// ports hold the connect bits, change mask zero.
`timescale 1ns / 1ps

module usb_hub_port_feature_tracker
  import uhpft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // feature_sel[7:0], port_index[23:8]
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // accepted[0], status_word[32:1],
                                     // report_valid[33], report_mask[41:34]
);

  logic in_valid_q;
  req_t in_req_q;
  logic out_valid_q;
  res_t out_res_q;
  res_t res;
  logic out_free, advance;

  // Stage control: the request commits when the result register has room
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q.mode        <= mode_e'(s_axis_tuser);
      in_req_q.feature_sel <= s_axis_tdata[7:0];
      in_req_q.port_index  <= s_axis_tdata[23:8];
    end
  end

  uhpft_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_req_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.report_mask, out_res_q.report_valid,
                          out_res_q.status_word, out_res_q.accepted};

endmodule
